/* rtl/core/rkns_pkg.sv */
`timescale 1ns / 1ps
package rkns_pkg;
    localparam int MAX_POINTS_DEF  = 1024;
    localparam int MAX_RESULTS_DEF = 16;
    localparam int DIST_W          = 34;
    localparam int IDX_W           = 10;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_MATCH     = 2'd0;
    localparam logic [1:0] ST_NO_NORMAL = 2'd1;
    localparam logic [1:0] ST_NO_MATCH  = 2'd2;

    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_MAXM   = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } req_t;

    typedef struct packed {
        logic [9:0] match_index;
        logic       valid_res;
        logic [1:0] status;
        logic       last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT,
        S_OUT
    } state_t;
endpackage

/* rtl/core/radius_k_nearest_search_top.sv */
`timescale 1ns / 1ps
// Radius-limited k-nearest search. Append and clear requests are handled in idle.
// A search streams the point store through a one-read-per-cycle memory port
// and a three-stage distance pipeline, then emits the ranked results (up to
// max_matches, clamped to 1..MAX_RESULTS) while the ranked list is read out.
// A zero normal is answered with a single no-normal result. The ranked list is
// a shift-insert register row updated once per in-radius point.
module radius_k_nearest_search_top
    import rkns_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int MAX_RESULTS = MAX_RESULTS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [33:0] cfg_data
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int RW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int BW = $clog2(MAX_RESULTS + 1);

    logic [47:0] mem [MAX_POINTS];
    logic [47:0] rd_data;
    logic [AW-1:0] rd_addr;

    logic [DIST_W-1:0] radius_reg;
    logic [4:0]        maxm_reg;
    logic [CW-1:0]     count_reg;
    state_t            state_reg, state_next;
    logic [CW-1:0]     scan_reg;
    logic signed [15:0] sx_reg, sy_reg, sz_reg;
    logic [BW-1:0]     limit_reg;

    // pipeline: p1 = read issued, p2 = differences, p3 = distance
    logic              v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]     i1_reg, i2_reg, i3_reg;
    logic signed [16:0] dx_reg, dy_reg, dz_reg;
    logic [DIST_W-1:0] d3_reg;

    logic [DIST_W-1:0] bd_reg [MAX_RESULTS];
    logic [IDX_W-1:0]  bi_reg [MAX_RESULTS];
    logic [BW-1:0]     bc_reg;
    logic [BW-1:0]     emit_reg;

    logic              ov_reg;
    res_t              od_reg;

    logic accept;
    logic out_free;

    logic [DIST_W-1:0] d3_next;
    logic [33:0] qx, qy, qz;

    assign cfg_ready = 1'b1;
    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            maxm_reg   <= 5'd1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_RADIUS)
                radius_reg <= cfg_data;
            else
                maxm_reg <= cfg_data[4:0];
        end
    end

    assign rd_addr = scan_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && in_data.kind == KIND_APPEND && count_reg < CW'(MAX_POINTS))
            mem[count_reg[AW-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && in_data.kind == KIND_SEARCH)
                     begin
                         if (in_data.norm_x == 0 && in_data.norm_y == 0
                             && in_data.norm_z == 0)
                             state_next = S_OUT;
                         else
                             state_next = S_SCAN;
                     end
            S_SCAN:  if (scan_reg >= count_reg) state_next = S_DRAIN;
            S_DRAIN: if (!v1_reg && !v2_reg && !v3_reg) state_next = S_EMIT;
            S_EMIT:  if (out_free && (bc_reg == '0 || emit_reg + 1'b1 == bc_reg))
                         state_next = S_IDLE;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic [4:0] lim_c;
    always_comb
    begin
        lim_c = (in_data.kind == KIND_SEARCH) ? maxm_reg : 5'd1;
        if (lim_c == 5'd0) lim_c = 5'd1;
    end

    // rank insertion: entries with larger distance shift down
    logic [MAX_RESULTS-1:0] gt;
    always_comb
    begin
        for (int j = 0; j < MAX_RESULTS; j++)
            gt[j] = (BW'(j) < bc_reg) && (bd_reg[j] > d3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            bc_reg    <= '0;
            emit_reg  <= '0;
            ov_reg    <= 1'b0;
            limit_reg <= BW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                unique case (in_data.kind)
                    KIND_CLEAR:  count_reg <= '0;
                    KIND_APPEND: if (count_reg < CW'(MAX_POINTS)) count_reg <= count_reg + 1'b1;
                    default: ;
                endcase
                scan_reg <= '0;
                bc_reg   <= '0;
                emit_reg <= '0;
                if (32'(lim_c) > MAX_RESULTS)
                    limit_reg <= BW'(MAX_RESULTS);
                else
                    limit_reg <= BW'(lim_c);
            end
            v1_reg <= (state_reg == S_SCAN) && (scan_reg < count_reg);
            if (state_reg == S_SCAN && scan_reg < count_reg)
                scan_reg <= scan_reg + 1'b1;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (d3_next <= radius_reg);
            if (v3_reg)
            begin
                if (bc_reg < limit_reg) bc_reg <= bc_reg + 1'b1;
            end
            if ((state_reg == S_OUT || state_reg == S_EMIT) && out_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (state_reg == S_EMIT && out_free)
                emit_reg <= emit_reg + 1'b1;
        end
    end

    assign qx = 34'(dx_reg * dx_reg);
    assign qy = 34'(dy_reg * dy_reg);
    assign qz = 34'(dz_reg * dz_reg);
    assign d3_next = qx + qy + qz;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= in_data.pos_x;
            sy_reg <= in_data.pos_y;
            sz_reg <= in_data.pos_z;
        end
        i1_reg <= rd_addr;
        i2_reg <= i1_reg;
        i3_reg <= i2_reg;
        dx_reg <= 17'(sx_reg) - 17'($signed(rd_data[47:32]));
        dy_reg <= 17'(sy_reg) - 17'($signed(rd_data[31:16]));
        dz_reg <= 17'(sz_reg) - 17'($signed(rd_data[15:0]));
        d3_reg <= d3_next;
        if (v3_reg)
        begin
            for (int j = MAX_RESULTS - 1; j >= 0; j--)
            begin
                if (BW'(j) < limit_reg)
                begin
                    if (j > 0 && gt[(j > 0) ? j - 1 : 0])
                    begin
                        bd_reg[j] <= bd_reg[(j > 0) ? j - 1 : 0];
                        bi_reg[j] <= bi_reg[(j > 0) ? j - 1 : 0];
                    end
                    else if (gt[j] || BW'(j) == bc_reg)
                    begin
                        bd_reg[j] <= d3_reg;
                        bi_reg[j] <= IDX_W'(i3_reg);
                    end
                end
            end
        end
        if (state_reg == S_OUT && out_free)
            od_reg <= '{match_index: '0, valid_res: 1'b0, status: ST_NO_NORMAL, last: 1'b1};
        if (state_reg == S_EMIT && out_free)
        begin
            if (bc_reg == '0)
                od_reg <= '{match_index: '0, valid_res: 1'b0, status: ST_NO_MATCH,
                            last: 1'b1};
            else
                od_reg <= '{match_index: bi_reg[emit_reg[RW-1:0]], valid_res: 1'b1,
                            status: ST_MATCH, last: (emit_reg + 1'b1 == bc_reg)};
        end
    end
endmodule

/* rtl/core/rkns_checker.sv */
`timescale 1ns / 1ps
module rkns_checker
    import rkns_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input res_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |-> out_data.match_index == '0 && out_data.last)
        else $error("bad non-match result");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.valid_res == (out_data.status == ST_MATCH))
        else $error("status and valid disagree");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("request taken mid-search");
endmodule

bind radius_k_nearest_search_top rkns_checker u_rkns_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import rkns_pkg::*;

    localparam longint unsigned RADIUS_TOP = 64'd12884508675;

    class knn_scoreboard;
        shortint px[MAX_POINTS_DEF];
        shortint py[MAX_POINTS_DEF];
        shortint pz[MAX_POINTS_DEF];
        int unsigned npts;
        longint unsigned radius_sq;
        int unsigned match_cap;
        res_t match_queue[$];
        int errors;
        int searches;
        int results;

        function new();
            npts = 0;
            radius_sq = 0;
            match_cap = 1;
            errors = 0;
            searches = 0;
            results = 0;
        endfunction

        function void queue_result(res_t e);
            match_queue.insert(match_queue.size(), e);
        endfunction

        function void set_reg(logic idx, longint unsigned v);
            if (idx == REG_RADIUS)
                radius_sq = v & ((64'd1 << 34) - 1);
            else
                match_cap = v & 5'h1f;
        endfunction

        function void note_request(req_t r);
            longint unsigned near_d[MAX_RESULTS_DEF];
            int unsigned near_i[MAX_RESULTS_DEF];
            int unsigned held;
            int unsigned lim;
            int unsigned pos;
            int unsigned j;
            longint dx;
            longint dy;
            longint dz;
            longint unsigned d;
            res_t e;
            case (r.kind)
                KIND_CLEAR: npts = 0;
                KIND_APPEND:
                begin
                    if (npts < MAX_POINTS_DEF)
                    begin
                        px[npts] = r.pos_x;
                        py[npts] = r.pos_y;
                        pz[npts] = r.pos_z;
                        npts++;
                    end
                end
                KIND_SEARCH:
                begin
                    searches++;
                    e = '0;
                    e.last = 1'b1;
                    if (r.norm_x == 0 && r.norm_y == 0 && r.norm_z == 0)
                    begin
                        e.status = ST_NO_NORMAL;
                        queue_result(e);
                        return;
                    end
                    lim = (match_cap == 0) ? 1 :
                          (match_cap > MAX_RESULTS_DEF) ? MAX_RESULTS_DEF : match_cap;
                    held = 0;
                    for (int unsigned i = 0; i < npts; i++)
                    begin
                        dx = longint'(r.pos_x) - longint'(px[i]);
                        dy = longint'(r.pos_y) - longint'(py[i]);
                        dz = longint'(r.pos_z) - longint'(pz[i]);
                        d = dx * dx + dy * dy + dz * dz;
                        if (d > radius_sq)
                            continue;
                        // equal distance stays behind earlier (lower) indices
                        pos = held;
                        while (pos > 0 && near_d[pos - 1] > d)
                            pos--;
                        if (pos >= lim)
                            continue;
                        j = (held < lim) ? held : lim - 1;
                        while (j > pos)
                        begin
                            near_d[j] = near_d[j - 1];
                            near_i[j] = near_i[j - 1];
                            j--;
                        end
                        near_d[pos] = d;
                        near_i[pos] = i;
                        if (held < lim)
                            held++;
                    end
                    if (held == 0)
                    begin
                        e.status = ST_NO_MATCH;
                        queue_result(e);
                        return;
                    end
                    for (int unsigned k = 0; k < held; k++)
                    begin
                        e.match_index = near_i[k][9:0];
                        e.valid_res = 1'b1;
                        e.status = ST_MATCH;
                        e.last = (k + 1 == held);
                        queue_result(e);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(res_t r);
            res_t e;
            results++;
            if (match_queue.size() == 0)
            begin
                $error("unexpected result %p", r);
                errors++;
                return;
            end
            e = match_queue.pop_front();
            if (r.match_index !== e.match_index)
            begin
                $error("match_index: expected %0d, actual %0d", e.match_index, r.match_index);
                errors++;
            end
            if (r.valid_res !== e.valid_res)
            begin
                $error("valid_res: expected %0d, actual %0d", e.valid_res, r.valid_res);
                errors++;
            end
            if (r.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, r.status);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last: expected %0d, actual %0d", e.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    req_t        in_data;
    logic        out_valid;
    logic        out_ready;
    res_t        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [33:0] cfg_data;

    knn_scoreboard sb = new();
    bit quiet = 0;
    int hold_asks = 0;
    int items = 0;
    int cfg_writes = 0;

    radius_k_nearest_search_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall bursts plus long hold-offs on request
    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_valid && out_ready)
                    sb.check_result(out_data);
                if (hold_seen != hold_asks)
                begin
                    hold_seen = hold_asks;
                    stall_left = 400;
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(0, 9);
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    task automatic send(req_t r);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
        items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.match_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, longint unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[33:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, v);
        cfg_writes++;
    endtask

    function automatic req_t make_req(logic [1:0] k, shortint x, shortint y, shortint z,
                                      shortint nx, shortint ny, shortint nz);
        req_t r;
        r.kind = k;
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        r.norm_x = nx;
        r.norm_y = ny;
        r.norm_z = nz;
        return r;
    endfunction

    function automatic shortint near(shortint c, int spread);
        int v;
        v = int'(c) + $urandom_range(0, 2 * spread) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return shortint'(v);
    endfunction

    function automatic shortint rnd16();
        return shortint'($urandom());
    endfunction

    function automatic req_t rnd_search(shortint cx, shortint cy, shortint cz, int spread);
        shortint nx;
        shortint ny;
        shortint nz;
        nx = 0;
        ny = 0;
        nz = 0;
        if ($urandom_range(0, 7) != 0)
        begin
            case ($urandom_range(0, 3))
                0: nx = rnd16();
                1: ny = shortint'(1 << $urandom_range(0, 15));
                2: nz = rnd16();
                default:
                begin
                    nx = rnd16();
                    ny = rnd16();
                    nz = rnd16() | 16'h1;
                end
            endcase
        end
        return make_req(KIND_SEARCH, near(cx, spread), near(cy, spread), near(cz, spread),
                        nx, ny, nz);
    endfunction

    initial
    begin
        shortint cx;
        shortint cy;
        shortint cz;
        int spread;
        int n;
        longint unsigned rad;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_RADIUS;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, zero normal, ignored kind, extremes
        send(make_req(KIND_SEARCH, 0, 0, 0, 1, 0, 0));
        send(make_req(KIND_SEARCH, 5, 5, 5, 0, 0, 0));
        send(make_req(KIND_UNUSED, -1, -1, -1, -1, -1, -1));
        send(make_req(KIND_APPEND, -32768, -32768, -32768, 0, 0, 0));
        send(make_req(KIND_APPEND, 32767, 32767, 32767, 0, 0, 0));
        send(make_req(KIND_APPEND, 0, 0, 0, 0, 0, 0));
        send(make_req(KIND_APPEND, 0, 0, 0, 0, 0, 0));
        send(make_req(KIND_SEARCH, 32767, 32767, 32767, 0, 0, -32768));
        send(make_req(KIND_SEARCH, 1, 0, 0, 0, 0, 1));
        write_reg(REG_RADIUS, RADIUS_TOP);
        write_reg(REG_MAXM, 16);
        send(make_req(KIND_SEARCH, -32768, -32768, -32768, 32767, 0, 0));
        send(make_req(KIND_SEARCH, 32767, 32767, 32767, 0, 1, 0));
        write_reg(REG_MAXM, 0);
        send(make_req(KIND_SEARCH, 0, 0, 0, 0, -1, 0));
        write_reg(REG_MAXM, 31);
        send(make_req(KIND_SEARCH, 1, 1, 1, 0, 0, 7));
        send(make_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
        send(make_req(KIND_SEARCH, 0, 0, 0, 3, 3, 3));

        // scatter points over the full range, then search them
        write_reg(REG_RADIUS, 64'd6_000_000_000);
        for (int i = 0; i < 40; i++)
            send(make_req(KIND_APPEND, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));
        send(rnd_search(0, 0, 0, 32767));
        send(rnd_search(0, 0, 0, 32767));
        send(make_req(KIND_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));

        for (int ph = 0; items < 460; ph++)
        begin
            if (items > 400)
                quiet = 1;
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: rad = 0;
                    1: rad = RADIUS_TOP;
                    2: rad = {$urandom(), $urandom()} % (RADIUS_TOP + 1);
                    default: rad = $urandom_range(0, 4_000_000);
                endcase
                write_reg(REG_RADIUS, rad);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_MAXM, $urandom_range(0, 31));
            cx = rnd16();
            cy = rnd16();
            cz = rnd16();
            spread = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 1500);
            send(make_req(KIND_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()));
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
            begin
                send(make_req(KIND_APPEND, near(cx, spread), near(cy, spread),
                              near(cz, spread), rnd16(), rnd16(), rnd16()));
                if ($urandom_range(0, 9) == 0)
                    send(make_req(KIND_UNUSED, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                                  rnd16()));
                // duplicate a point now and then to force distance ties
                if ($urandom_range(0, 7) == 0)
                    send(make_req(KIND_APPEND, cx, cy, cz, 0, 0, 0));
            end
            if (ph == 6)
                hold_asks++;
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                send(rnd_search(cx, cy, cz, spread));
            if (ph == 6 || ph == 12)
                drain();
        end

        drain();
        $display("Covered %0d requests, %0d searches, %0d results, %0d register writes.",
                 items, sb.searches, sb.results, cfg_writes);
        if (sb.errors == 0 && sb.match_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
